[hdl/ecal_pkg.sv]
`default_nettype none

package ecal_pkg;

    // Field widths
    localparam int unsigned InWidth    = 32;
    localparam int unsigned OutWidth   = 40;
    localparam int unsigned DaysWidth  = 16;
    localparam int unsigned YearWidth  = 12;

    // Reciprocal division: q = (x * RECIP) >> shift, exact over each dividend range
    //   days:    (secs >> 7) / 675, 25-bit dividend, shift 35
    //   hours:   (rem >> 4) / 225,  13-bit dividend, shift 21
    //   minutes: (rem >> 2) / 15,   10-bit dividend, shift 14
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;   // ceil(2^35 / 675)
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;       // ceil(2^21 / 225)
    localparam logic [10:0] MIN_RECIP     = 11'd1093;       // ceil(2^14 / 15)
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // Epoch year and its residues mod 4, 100 and 400
    localparam logic [11:0] EPOCH_YEAR = 12'd1970;
    localparam logic [1:0]  EPOCH_Y4   = 2'd2;
    localparam logic [6:0]  EPOCH_Y100 = 7'd70;
    localparam logic [8:0]  EPOCH_Y400 = 9'd370;

    localparam logic [8:0]  DAYS_LEAP  = 9'd366;
    localparam logic [8:0]  DAYS_REG   = 9'd365;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_DAY_QUO,
        OP_DAY_REM,
        OP_HOUR_QUO,
        OP_HOUR_REM,
        OP_MIN_QUO,
        OP_YEAR_SETUP,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_IN_WAIT,
        C_YEAR_MORE,
        C_MONTH_LOW,
        C_OUT_BUSY
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_DAY_QUO    = 4'd1;
    localparam step_t STEP_DAY_REM    = 4'd2;
    localparam step_t STEP_HOUR_QUO   = 4'd3;
    localparam step_t STEP_HOUR_REM   = 4'd4;
    localparam step_t STEP_MIN_QUO    = 4'd5;
    localparam step_t STEP_YEAR_SETUP = 4'd6;
    localparam step_t STEP_YEAR       = 4'd7;
    localparam step_t STEP_MONTH      = 4'd8;
    localparam step_t STEP_EMIT       = 4'd9;

    // One control word: operation, jump when cond holds, else advance or wrap
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  wrap;
        step_t target;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t op;
    } ecal_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic in_wait;
        logic year_more;
        logic month_low;
        logic out_busy;
    } dp_status_t;

    // Microprogram
    function automatic uword_t ucode_rom(input step_t s);
        uword_t w;
        unique case (s)
            STEP_IDLE:       w = '{OP_LOAD,       C_IN_WAIT,   1'b0, STEP_IDLE};
            STEP_DAY_QUO:    w = '{OP_DAY_QUO,    C_NONE,      1'b0, STEP_IDLE};
            STEP_DAY_REM:    w = '{OP_DAY_REM,    C_NONE,      1'b0, STEP_IDLE};
            STEP_HOUR_QUO:   w = '{OP_HOUR_QUO,   C_NONE,      1'b0, STEP_IDLE};
            STEP_HOUR_REM:   w = '{OP_HOUR_REM,   C_NONE,      1'b0, STEP_IDLE};
            STEP_MIN_QUO:    w = '{OP_MIN_QUO,    C_NONE,      1'b0, STEP_IDLE};
            STEP_YEAR_SETUP: w = '{OP_YEAR_SETUP, C_NONE,      1'b0, STEP_IDLE};
            STEP_YEAR:       w = '{OP_YEAR,       C_YEAR_MORE, 1'b0, STEP_YEAR};
            STEP_MONTH:      w = '{OP_MONTH,      C_MONTH_LOW, 1'b0, STEP_MONTH};
            STEP_EMIT:       w = '{OP_EMIT,       C_OUT_BUSY,  1'b1, STEP_EMIT};
            default:         w = '{OP_LOAD,       C_NONE,      1'b1, STEP_IDLE};
        endcase
        return w;
    endfunction

    // Gregorian rule from the residue counters
    function automatic logic leap_of(input logic [1:0] y4, input logic [6:0] y100,
                                     input logic [8:0] y400);
        return (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));
    endfunction

    // First day of the year (from 0) of month idx+1
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        // March and later move by one day in a leap year
        if (leap && (idx >= 4'd2)) begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/epoch_seconds_to_calendar_core.sv]
// Channel   Dir  tdata bits (lowest first)
// s_        in   epoch_seconds[31:0]
// m_        out  second_of_minute[5:0], minute_of_hour[11:6], hour_of_day[16:12],
//                day_of_month[21:17], month_of_year[25:22], full_year[37:26], zero[39:38]
//
// One word in flight. The time an item takes grows with its year and with how early
// in the year its month lies, set by the year-stripping loop of the microprogram (one
// year per step) and the month search, after six fixed steps that split the seconds
// count into day, hour, minute and second by reciprocal multiplication.
// s_tready is high only at the idle step; a finished word waits in the output
// register while the next word is taken. Reset clears the step counter and
// m_tvalid.
`default_nettype none

module epoch_seconds_to_calendar_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // epoch_seconds
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // second, minute, hour, day, month, year, pad
);
    import ecal_pkg::*;

    ecal_ctl_t  ctl;
    dp_status_t status;

    ecal_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctl     (ctl)
    );

    ecal_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .status   (status)
    );

    assign s_tready = (ctl.op == OP_LOAD);

endmodule

`default_nettype wire

[hdl/ecal_seq.sv]
`default_nettype none

module ecal_seq (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ecal_pkg::dp_status_t status,
    output ecal_pkg::ecal_ctl_t     ctl
);
    import ecal_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t cw;
    logic   hit;

    // Fetch and decode the control word
    always_comb begin
        cw = ucode_rom(step_reg);
        unique case (cw.cond)
            C_NONE:      hit = 1'b0;
            C_IN_WAIT:   hit = status.in_wait;
            C_YEAR_MORE: hit = status.year_more;
            C_MONTH_LOW: hit = status.month_low;
            C_OUT_BUSY:  hit = status.out_busy;
            default:     hit = 1'b0;
        endcase
        if (hit) begin
            step_next = cw.target;
        end else if (cw.wrap) begin
            step_next = STEP_IDLE;
        end else begin
            step_next = step_reg + 4'd1;
        end
        ctl.op = cw.op;
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[hdl/ecal_dp.sv]
`default_nettype none

module ecal_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ecal_pkg::ecal_ctl_t         ctl,
    input  wire logic                        s_tvalid,
    input  wire logic [ecal_pkg::InWidth-1:0] s_tdata,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [ecal_pkg::OutWidth-1:0]    m_tdata,
    output ecal_pkg::dp_status_t             status
);
    import ecal_pkg::*;

    logic [31:0]          rem_reg;
    logic [DaysWidth-1:0] days_reg;
    logic [4:0]           hour_reg;
    logic [5:0]           min_reg;
    logic [5:0]           sec_reg;
    logic [YearWidth-1:0] year_reg;
    logic [1:0]           y4_reg;
    logic [6:0]           y100_reg;
    logic [8:0]           y400_reg;
    logic [3:0]           month_reg;
    logic [OutWidth-1:0]  out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [50:0] day_prod;
    logic [31:0] day_base;
    logic [26:0] hour_prod;
    logic [16:0] hour_base;
    logic [20:0] min_prod;
    logic [11:0] min_base;
    logic [11:0] sec_diff;
    logic        leap;
    logic [8:0]  year_len;
    logic        year_ge;
    logic [8:0]  mstart;
    logic        month_ge;
    logic        out_busy;
    logic        emit_load;

    // Reciprocal products, compares and table lookups
    always_comb begin
        day_prod  = {26'd0, rem_reg[31:7]} * {25'd0, DAY_RECIP};
        day_base  = {16'd0, days_reg} * {15'd0, SECS_PER_DAY};
        hour_prod = {14'd0, rem_reg[16:4]} * {13'd0, HOUR_RECIP};
        hour_base = {12'd0, hour_reg} * {5'd0, SECS_PER_HOUR};
        min_prod  = {11'd0, rem_reg[11:2]} * {10'd0, MIN_RECIP};
        min_base  = {6'd0, min_reg} * {6'd0, SECS_PER_MIN};
        sec_diff  = rem_reg[11:0] - min_base;
        leap      = leap_of(y4_reg, y100_reg, y400_reg);
        year_len  = leap ? DAYS_LEAP : DAYS_REG;
        year_ge   = days_reg >= {7'd0, year_len};
        mstart    = month_start(leap, month_reg - 4'd1);
        month_ge  = days_reg >= {7'd0, mstart};
        out_busy  = out_valid_reg && !m_tready;
        emit_load = (ctl.op == OP_EMIT) && !out_busy;

        status.in_wait   = !s_tvalid;
        status.year_more = year_ge;
        status.month_low = !month_ge;
        status.out_busy  = out_busy;

        if (emit_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    rem_reg <= s_tdata;
                end
            end
            OP_DAY_QUO: begin
                days_reg <= day_prod[50:35];
            end
            OP_DAY_REM: begin
                // seconds within the day
                rem_reg <= rem_reg - day_base;
            end
            OP_HOUR_QUO: begin
                hour_reg <= hour_prod[25:21];
            end
            OP_HOUR_REM: begin
                // seconds within the hour
                rem_reg <= rem_reg - {15'd0, hour_base};
            end
            OP_MIN_QUO: begin
                min_reg <= min_prod[19:14];
            end
            OP_YEAR_SETUP: begin
                sec_reg   <= sec_diff[5:0];
                year_reg  <= EPOCH_YEAR;
                y4_reg    <= EPOCH_Y4;
                y100_reg  <= EPOCH_Y100;
                y400_reg  <= EPOCH_Y400;
                month_reg <= 4'd12;
            end
            OP_YEAR: begin
                // strip one whole year
                if (year_ge) begin
                    days_reg <= days_reg - {7'd0, year_len};
                    year_reg <= year_reg + 12'd1;
                    y4_reg   <= y4_reg + 2'd1;
                    y100_reg <= (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
                    y400_reg <= (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
                end
            end
            OP_MONTH: begin
                // search down from December
                if (month_ge) begin
                    days_reg <= days_reg - {7'd0, mstart};
                end else begin
                    month_reg <= month_reg - 4'd1;
                end
            end
            OP_EMIT: begin
                if (emit_load) begin
                    out_reg <= {2'b00, year_reg, month_reg,
                                5'(days_reg + 16'd1), hour_reg, min_reg, sec_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // Output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

[hdl/ecal_checker.sv]
`default_nettype none

module ecal_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // Stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Busy after taking a word
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a take");

    // Idle stays ready
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid |=> s_tready)
        else $error("ready dropped without a word");

    // A new result appears only at the end of a computation
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

    // Fields in range
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) &&
                     (m_tdata[16:12] < 5'd24) && (m_tdata[21:17] != 5'd0) &&
                     (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] < 4'd13) &&
                     (m_tdata[39:38] == 2'd0))
        else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_core ecal_checker u_ecal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/tb_epoch_seconds_to_calendar_core.sv]
`default_nettype none

module tb_epoch_seconds_to_calendar_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned FIRST_YEAR    = 1970;
    localparam int unsigned LAST_DAY      = 49709;   // last day with a full 86400 s below 2^32
    localparam int unsigned RANDOM_WORDS  = 550;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned PRINT_CAP     = 50;

    // Output word, highest field first so the layout matches m_tdata
    typedef struct packed {
        logic [1:0]  pad;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    typedef struct {
        logic [31:0] secs;
        bit          hold_for_idle;   // sender waits until all dates are back
    } stamp_t;

    typedef struct {
        logic [31:0] secs;
        calendar_t   date;
    } date_entry_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // epoch_seconds[31:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // second[5:0], minute[11:6], hour[16:12], day[21:17],
                                   // month[25:22], year[37:26], zero[39:38]

    stamp_t      stamp_queue[$];
    date_entry_t date_queue[$];
    int unsigned outstanding = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    epoch_seconds_to_calendar_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gregorian rule
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Day of the year (from 0) on which month m0+1 starts
    function automatic int unsigned month_first_day(input bit leap, input int unsigned m0);
        int unsigned starts[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        return starts[m0] + ((leap && m0 >= 2) ? 1 : 0);
    endfunction

    // Days from the epoch to the first of month m (1..12) of year y
    function automatic int unsigned days_to_month(input int unsigned y, input int unsigned m);
        int unsigned d = 0;
        for (int unsigned yy = FIRST_YEAR; yy < y; yy++) begin
            d += leap_year(yy) ? 366 : 365;
        end
        return d + month_first_day(leap_year(y), m - 1);
    endfunction

    // Calendar date of a seconds count
    function automatic calendar_t epoch_to_calendar(input logic [31:0] secs);
        int unsigned days;
        int unsigned rem;
        int unsigned year;
        int unsigned len;
        int unsigned month;
        calendar_t   c;
        days  = secs / SECS_PER_DAY;
        rem   = secs % SECS_PER_DAY;
        year  = FIRST_YEAR;
        len   = leap_year(year) ? 366 : 365;
        // strip whole years; a day count that uses up a year lands on Jan 1
        while (days >= len) begin
            days -= len;
            year++;
            len = leap_year(year) ? 366 : 365;
        end
        month = 1;
        for (int m0 = 11; m0 >= 1 && month == 1; m0--) begin
            if (days >= month_first_day(leap_year(year), m0)) begin
                days -= month_first_day(leap_year(year), m0);
                month = m0 + 1;
            end
        end
        c        = '0;
        c.second = 6'(rem % SECS_PER_MIN);
        c.minute = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
        c.hour   = 5'(rem / SECS_PER_HOUR);
        c.day    = 5'(days + 1);
        c.month  = 4'(month);
        c.year   = 12'(year);
        return c;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input logic [31:0] secs, input string name,
                               input int unsigned got, input int unsigned want);
        if (got != want) begin
            flag_mismatch($sformatf("secs=%0d %s got %0d want %0d", secs, name, got, want));
        end
    endtask

    // Seconds count near a month edge of a random year
    function automatic logic [31:0] month_edge_secs();
        int unsigned d;
        longint unsigned v;
        d = days_to_month($urandom_range(FIRST_YEAR, 2105), $urandom_range(1, 12));
        if (d != 0 && $urandom_range(0, 1)) begin
            d--;
        end
        case ($urandom_range(0, 2))
            0:       v = longint'(d) * SECS_PER_DAY;
            1:       v = longint'(d) * SECS_PER_DAY + SECS_PER_DAY - 1;
            default: v = longint'(d) * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
        endcase
        return 32'(v);
    endfunction

    // Stimulus, reset and end of run
    initial begin
        logic [31:0] directed[];
        stamp_t      st;
        directed = '{
            32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
            32'd31535999, 32'd31536000,          // end of 1970, start of 1971
            32'd68083200, 32'd68169600,          // Feb 28 and leap day 1972
            32'd94694399, 32'd94694400,          // end of the first leap year
            32'd951782400, 32'd951868800,        // leap day 2000 (div by 400), Mar 1
            32'd4107456000, 32'd4107542400,      // 2100 is not leap: Feb 28, Mar 1
            32'h7FFF_FFFF, 32'h8000_0000,
            32'hFFFF_FFFE, 32'hFFFF_FFFF         // largest input, Feb 7 2106
        };
        foreach (directed[i]) begin
            st.secs          = directed[i];
            st.hold_for_idle = 1'b0;
            stamp_queue.push_back(st);
        end
        for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: st.secs = $urandom;
                4, 5:       st.secs = $urandom_range(0, LAST_DAY) * SECS_PER_DAY
                                      + (($urandom_range(0, 1)) ? 0 : SECS_PER_DAY - 1);
                6, 7, 8:    st.secs = month_edge_secs();
                default:    st.secs = ($urandom_range(0, 1)) ? $urandom_range(0, 200000)
                                      : 32'hFFFF_FFFF - $urandom_range(0, 2000000);
            endcase
            st.hold_for_idle = (i == 0) || ($urandom_range(0, 99) == 0);
            stamp_queue.push_back(st);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // sample away from the active edge so driver and monitor updates have settled
        do begin
            @(negedge aclk);
        end while (stamp_queue.size() != 0 || s_tvalid || outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (date_queue.size() != 0) begin
            flag_mismatch($sformatf("%0d dates never returned", date_queue.size()));
        end
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Sender: bursts of random length separated by random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            // word still waiting, hold it
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left--;
        end else if (stamp_queue.size() == 0 ||
                     (stamp_queue[0].hold_for_idle && (s_tvalid || outstanding != 0))) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= stamp_queue[0].secs;
            void'(stamp_queue.pop_front());
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 8);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
                burst_left--;
            end
        end
    end

    // Receiver: rotating ready pattern, reshuffled now and then
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age   = 0;

    always @(posedge aclk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'($urandom);
                2:       ready_pattern = 16'($urandom & $urandom);
                default: ready_pattern = 16'($urandom | $urandom);
            endcase
            if (ready_pattern == 16'h0000) begin
                ready_pattern = 16'h0001;
            end
            pattern_age = $urandom_range(20, 200);
        end else begin
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_age--;
        end
        m_tready <= ready_pattern[0];
    end

    // Monitor: predict on each accepted input, check each accepted date
    always @(posedge aclk) begin : date_monitor
        calendar_t   got;
        date_entry_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (date_queue.size() == 0) begin
                    flag_mismatch($sformatf("unexpected date word %h", m_tdata));
                end else begin
                    want = date_queue.pop_front();
                    check_field(want.secs, "second", got.second, want.date.second);
                    check_field(want.secs, "minute", got.minute, want.date.minute);
                    check_field(want.secs, "hour",   got.hour,   want.date.hour);
                    check_field(want.secs, "day",    got.day,    want.date.day);
                    check_field(want.secs, "month",  got.month,  want.date.month);
                    check_field(want.secs, "year",   got.year,   want.date.year);
                    check_field(want.secs, "pad",    got.pad,    want.date.pad);
                end
            end
            if (s_tvalid && s_tready) begin
                want.secs = s_tdata;
                want.date = epoch_to_calendar(s_tdata);
                date_queue.push_back(want);
            end
            outstanding <= date_queue.size();
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire
